// ----- rtl/pcp6_pkg.sv -----
package pcp6_pkg;

   localparam int LANES   = 8;
   localparam int COEF_W  = 16;
   localparam int DIG_W   = 6;
   localparam int WORD_W  = LANES * DIG_W;
   localparam int BYTE_W  = 8;
   localparam int BYTES   = WORD_W / BYTE_W;
   localparam int OP_W    = 2;
   localparam int RM_W    = 16;

   localparam int MODULUS_Q_DEFAULT = 7681;
   localparam logic [RM_W-1:0] RM_RESET = 16'd8737;

   // Bit position of the six-bit result inside the rounding product.
   localparam int ROUND_SHIFT = 26;
   // Rounding offset of the decompress path, half of 2^DIG_W.
   localparam int DEC_ROUND   = 32;

   localparam logic [OP_W-1:0] OP_COMPRESS   = 2'd0;
   localparam logic [OP_W-1:0] OP_COMPARE    = 2'd1;
   localparam logic [OP_W-1:0] OP_DECOMPRESS = 2'd2;

   // Load enables of the three lane pipeline stages.
   typedef struct packed {
      logic load_quo;
      logic load_rem;
      logic load_res;
   } pcp6_load_type;

endpackage

// ----- rtl/pcp6_lane.sv -----
module pcp6_lane #(
   parameter int MODULUS_Q = pcp6_pkg::MODULUS_Q_DEFAULT
) (
   input  logic                          clock,
   input  pcp6_pkg::pcp6_load_type       load,
   input  logic [pcp6_pkg::COEF_W-1:0]   coef,
   input  logic [pcp6_pkg::DIG_W-1:0]    digit,
   input  logic [pcp6_pkg::RM_W-1:0]     round_multiplier,
   output logic [pcp6_pkg::DIG_W-1:0]    comp,
   output logic [pcp6_pkg::COEF_W-1:0]   decomp
);
   import pcp6_pkg::*;

   // Reciprocal of the modulus; the quotient estimate is exact or one low.
   localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / MODULUS_Q);
   localparam int          HALF_Q = MODULUS_Q / 2;

   logic [48:0]        quo_prod;
   logic [COEF_W-1:0]  quo_in, quo_ff, coef_ff;
   logic [DIG_W-1:0]   digit_q_ff, digit_r_ff;
   logic [31:0]        sub_prod;
   logic [16:0]        rem_raw;
   logic [COEF_W-1:0]  rem_in, rem_ff;
   logic [22:0]        scaled;
   logic [38:0]        round_prod;
   logic [21:0]        dec_prod;
   logic [22:0]        dec_sum;
   logic [DIG_W-1:0]   comp_in, comp_ff;
   logic [COEF_W-1:0]  decomp_in, decomp_ff;

   assign quo_prod = 49'(coef) * 49'(RECIP);
   assign quo_in   = quo_prod[47:32];

   assign sub_prod = 32'(quo_ff) * 32'(MODULUS_Q);
   assign rem_raw  = 17'(32'(coef_ff) - sub_prod);
   assign rem_in   = (rem_raw >= 17'(MODULUS_Q)) ? 16'(rem_raw - 17'(MODULUS_Q))
                                                 : 16'(rem_raw);

   assign scaled     = {1'b0, rem_ff, {DIG_W{1'b0}}} + 23'(HALF_Q);
   assign round_prod = 39'(scaled) * 39'(round_multiplier);
   assign comp_in    = round_prod[ROUND_SHIFT +: DIG_W];

   assign dec_prod  = 22'(digit_r_ff) * 22'(MODULUS_Q);
   assign dec_sum   = 23'(dec_prod) + 23'(DEC_ROUND);
   assign decomp_in = dec_sum[DIG_W +: COEF_W];

   always_ff @(posedge clock) begin
      if (load.load_quo) begin
         quo_ff     <= quo_in;
         coef_ff    <= coef;
         digit_q_ff <= digit;
      end
      if (load.load_rem) begin
         rem_ff     <= rem_in;
         digit_r_ff <= digit_q_ff;
      end
      if (load.load_res) begin
         comp_ff   <= comp_in;
         decomp_ff <= decomp_in;
      end
   end

   assign comp   = comp_ff;
   assign decomp = decomp_ff;

endmodule

// ----- rtl/poly_compress_pack_6bit.sv -----
// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_stall  op, eight coefficients, packed bytes, last flag
// rsp_      out        rsp_valid/rsp_stall  packed bytes, mismatch byte, eight coefficients
// csr_      in         csr_valid/csr_ready  rounding multiplier
//
// A transaction passes the lane stages on its way to the result register; a new one is
// taken every cycle while req_stall is low, and the lane multiplications set the depth.
// Reset is synchronous and active high; it clears the stage valid bits, the mismatch
// accumulator and restores the multiplier to its reset value.
// A stall on the result side holds only the stages that are full behind it; empty
// stages still fill, so req_stall rises only once every stage holds a transaction.
module poly_compress_pack_6bit #(
   parameter int MODULUS_Q = pcp6_pkg::MODULUS_Q_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pcp6_pkg::OP_W-1:0]     req_op,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_0,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_1,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_2,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_3,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_4,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_5,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_6,
   input  logic [pcp6_pkg::COEF_W-1:0]   req_coef_7,
   input  logic [pcp6_pkg::WORD_W-1:0]   req_packed_in,
   input  logic                          req_last_group,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pcp6_pkg::WORD_W-1:0]   rsp_packed_out,
   output logic [pcp6_pkg::BYTE_W-1:0]   rsp_mismatch,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_0,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_1,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_2,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_3,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_4,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_5,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_6,
   output logic [pcp6_pkg::COEF_W-1:0]   rsp_out_7,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pcp6_pkg::RM_W-1:0]     csr_round_multiplier
);
   import pcp6_pkg::*;

   // Stage numbering: 1 input register, 2 quotient estimate, 3 remainder,
   // 4 rounded digit and decompressed value, 5 result register.
   localparam int STAGES = 5;

   logic [STAGES:1]     valid_ff, valid_in, ready;
   pcp6_load_type       lane_load;

   logic [RM_W-1:0]     rm_ff;
   logic [BYTE_W-1:0]   acc_ff, acc_in;

   logic [COEF_W-1:0]   coef_in [LANES];
   logic [COEF_W-1:0]   coef_ff [LANES];

   // Side information that travels alongside the lanes, stages 1 to 4.
   logic [OP_W-1:0]     op_ff   [1:4];
   logic                last_ff [1:4];
   logic [WORD_W-1:0]   pin_ff  [1:4];

   logic [DIG_W-1:0]    comp   [LANES];
   logic [COEF_W-1:0]   decomp [LANES];

   logic [WORD_W-1:0]   word;
   logic [WORD_W-1:0]   diff;
   logic [BYTE_W-1:0]   diff_or;

   logic [WORD_W-1:0]   packed_in;
   logic [BYTE_W-1:0]   mismatch_in;
   logic [COEF_W-1:0]   out_in [LANES];
   logic [WORD_W-1:0]   packed_ff;
   logic [BYTE_W-1:0]   mismatch_ff;
   logic [COEF_W-1:0]   out_ff [LANES];

   assign coef_in[0] = req_coef_0;
   assign coef_in[1] = req_coef_1;
   assign coef_in[2] = req_coef_2;
   assign coef_in[3] = req_coef_3;
   assign coef_in[4] = req_coef_4;
   assign coef_in[5] = req_coef_5;
   assign coef_in[6] = req_coef_6;
   assign coef_in[7] = req_coef_7;

   // A stage loads whenever it is empty or its contents move on this cycle.
   always_comb begin
      ready[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[1] = req_valid;
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = !ready[1];
   assign csr_ready = 1'b1;

   assign lane_load.load_quo = ready[2];
   assign lane_load.load_rem = ready[3];
   assign lane_load.load_res = ready[4];

   // Eight identical lanes, each digit of the packed input riding with its lane
   // for the decompress path.
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      pcp6_lane #(
         .MODULUS_Q(MODULUS_Q)
      ) u_lane (
         .clock            (clock),
         .load             (lane_load),
         .coef             (coef_ff[j]),
         .digit            (pin_ff[1][j*DIG_W +: DIG_W]),
         .round_multiplier (rm_ff),
         .comp             (comp[j]),
         .decomp           (decomp[j])
      );
      assign word[j*DIG_W +: DIG_W] = comp[j];
   end

   // Compare path: the six byte differences folded into one byte.
   always_comb begin
      diff    = word ^ pin_ff[4];
      diff_or = '0;
      for (int k = 0; k < BYTES; k++) begin
         diff_or = diff_or | diff[k*BYTE_W +: BYTE_W];
      end
   end

   // Result formation. The accumulator only moves on a compare transaction,
   // and clears once the last group of a polynomial has been reported.
   always_comb begin
      packed_in   = '0;
      mismatch_in = acc_ff;
      acc_in      = acc_ff;
      for (int j = 0; j < LANES; j++) begin
         out_in[j] = '0;
      end
      case (op_ff[4])
         OP_COMPRESS: begin
            packed_in = word;
         end
         OP_COMPARE: begin
            packed_in   = word;
            mismatch_in = acc_ff | diff_or;
            acc_in      = last_ff[4] ? '0 : (acc_ff | diff_or);
         end
         OP_DECOMPRESS: begin
            for (int j = 0; j < LANES; j++) begin
               out_in[j] = decomp[j];
            end
         end
         default: begin
            packed_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rm_ff    <= RM_RESET;
         acc_ff   <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
         if (csr_valid && csr_ready) begin
            rm_ff <= csr_round_multiplier;
         end
         if (ready[STAGES] && valid_ff[STAGES-1]) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Payload registers carry no reset; the valid bits qualify them.
   always_ff @(posedge clock) begin
      if (ready[1]) begin
         op_ff[1]   <= req_op;
         last_ff[1] <= req_last_group;
         pin_ff[1]  <= req_packed_in;
         for (int j = 0; j < LANES; j++) begin
            coef_ff[j] <= coef_in[j];
         end
      end
      for (int k = 2; k <= 4; k++) begin
         if (ready[k]) begin
            op_ff[k]   <= op_ff[k-1];
            last_ff[k] <= last_ff[k-1];
            pin_ff[k]  <= pin_ff[k-1];
         end
      end
      if (ready[STAGES]) begin
         packed_ff   <= packed_in;
         mismatch_ff <= mismatch_in;
         for (int j = 0; j < LANES; j++) begin
            out_ff[j] <= out_in[j];
         end
      end
   end

   assign rsp_valid      = valid_ff[STAGES];
   assign rsp_packed_out = packed_ff;
   assign rsp_mismatch   = mismatch_ff;
   assign rsp_out_0      = out_ff[0];
   assign rsp_out_1      = out_ff[1];
   assign rsp_out_2      = out_ff[2];
   assign rsp_out_3      = out_ff[3];
   assign rsp_out_4      = out_ff[4];
   assign rsp_out_5      = out_ff[5];
   assign rsp_out_6      = out_ff[6];
   assign rsp_out_7      = out_ff[7];

endmodule
